// ----- design/websocket_frame_deframer_macros.svh -----
// assertion helpers for the websocket frame deframer
`ifndef WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH

`ifndef SYNTH
// antecedent implies consequent in the same cycle
`define WSFD_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("wsfd check failed");
// antecedent implies consequent in the next cycle
`define WSFD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("wsfd check failed");
`else
`define WSFD_ASSERT_SAME(label, ante, cons)
`define WSFD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- design/wsfd_pkg.sv -----
package wsfd_pkg;

	localparam logic [3:0] OP_TEXT  = 4'h1;
	localparam logic [3:0] OP_CLOSE = 4'h8;
	localparam logic [3:0] OP_PING  = 4'h9;

	localparam logic [1:0] KIND_IGNORED = 2'd0;
	localparam logic [1:0] KIND_TEXT    = 2'd1;
	localparam logic [1:0] KIND_PING    = 2'd2;
	localparam logic [1:0] KIND_CLOSE   = 2'd3;

	localparam logic [6:0] LEN7_EXT16 = 7'd126;
	localparam logic [6:0] LEN7_EXT64 = 7'd127;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       has_byte;
		logic [3:0] frame_opcode;
		logic [1:0] frame_kind;
		logic       last_of_frame;
	} res_t;

	function automatic logic [1:0] kind_of(input logic [3:0] op);
		logic [1:0] k;
		case (op)
			OP_TEXT:  k = KIND_TEXT;
			OP_PING:  k = KIND_PING;
			OP_CLOSE: k = KIND_CLOSE;
			default:  k = KIND_IGNORED;
		endcase
		return k;
	endfunction

endpackage

// ----- design/websocket_frame_deframer.sv -----
// Receive-side WebSocket frame parser. One stream byte is taken per item and every
// accepted item is processed in the cycle it is accepted, so the block sustains one
// byte per clock while not stalled; a payload result is registered. The header
// state machine handles the opcode byte, the mask and length byte, a 2- or 8-byte
// big-endian extended length and a 4-byte masking key; payload bytes leave unmasked
// and tagged with opcode, kind and a last-of-frame mark, and a zero-length frame
// gives one result with has_byte low. The result side is an output register backed
// by one skid entry: in_stall rises only when both hold results that the consumer
// has not taken. Lengths wider than LENGTH_BITS saturate. Once a close frame has
// been delivered all input is consumed and dropped until reset.
`include "websocket_frame_deframer_macros.svh"

module websocket_frame_deframer
	import wsfd_pkg::*;
#(
	parameter int LENGTH_BITS = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] payload_byte,
	output logic       has_byte,
	output logic [3:0] frame_opcode,
	output logic [1:0] frame_kind,
	output logic       last_of_frame
);

	localparam int LW = LENGTH_BITS;

	localparam logic [2:0] PH_HDR0   = 3'd0;
	localparam logic [2:0] PH_HDR1   = 3'd1;
	localparam logic [2:0] PH_EXT    = 3'd2;
	localparam logic [2:0] PH_KEY    = 3'd3;
	localparam logic [2:0] PH_DATA   = 3'd4;
	localparam logic [2:0] PH_CLOSED = 3'd5;

	logic [2:0]    phase_q, phase_d;
	logic [3:0]    op_q, op_d;
	logic          mask_q, mask_d;
	logic [LW-1:0] rem_q, rem_d;
	logic [2:0]    cnt_q, cnt_d;
	logic [31:0]   key_q, key_d;
	logic [1:0]    kidx_q, kidx_d;

	logic          out_valid_q, skid_valid_q;
	res_t          out_q, skid_q;

	res_t          res;
	logic          res_vld;
	logic          take, gen, out_ready;
	logic          len_done, hdr_done, frame_end;
	logic [6:0]    len7;
	logic [1:0]    ksel;

	assign take      = in_valid & ~in_stall;
	assign gen       = take & res_vld;
	assign out_ready = ~out_valid_q | ~out_stall;
	assign len7      = data_byte[6:0];
	assign ksel      = ~kidx_q;

	always_comb begin
		phase_d   = phase_q;
		op_d      = op_q;
		mask_d    = mask_q;
		rem_d     = rem_q;
		cnt_d     = cnt_q;
		key_d     = key_q;
		kidx_d    = kidx_q;
		len_done  = 1'b0;
		hdr_done  = 1'b0;
		frame_end = 1'b0;
		res_vld   = 1'b0;
		res.payload_byte  = 8'd0;
		res.has_byte      = 1'b0;
		res.frame_opcode  = op_q;
		res.frame_kind    = kind_of(op_q);
		res.last_of_frame = 1'b0;
		unique case (phase_q)
			PH_HDR1: begin
				mask_d = data_byte[7];
				key_d  = '0;
				rem_d  = '0;
				if (len7 == LEN7_EXT16) begin
					cnt_d   = 3'd1;
					phase_d = PH_EXT;
				end else if (len7 == LEN7_EXT64) begin
					cnt_d   = 3'd7;
					phase_d = PH_EXT;
				end else begin
					rem_d    = LW'(len7);
					len_done = 1'b1;
				end
			end
			PH_EXT: begin
				if (rem_q[LW-1 -: 8] != 8'd0) begin
					rem_d = '1;
				end else begin
					rem_d = {rem_q[LW-9:0], data_byte};
				end
				if (cnt_q == 3'd0) begin
					len_done = 1'b1;
				end else begin
					cnt_d = cnt_q - 3'd1;
				end
			end
			PH_KEY: begin
				key_d = {key_q[23:0], data_byte};
				if (cnt_q == 3'd0) begin
					hdr_done = 1'b1;
				end else begin
					cnt_d = cnt_q - 3'd1;
				end
			end
			PH_DATA: begin
				rem_d  = rem_q - LW'(1);
				kidx_d = kidx_q + 2'd1;
				res_vld           = 1'b1;
				res.payload_byte  = data_byte ^ key_q[{ksel, 3'b000} +: 8];
				res.has_byte      = 1'b1;
				res.last_of_frame = (rem_d == '0);
				frame_end         = res.last_of_frame;
			end
			PH_CLOSED: begin
			end
			default: begin
				op_d    = data_byte[3:0];
				phase_d = PH_HDR1;
			end
		endcase
		if (len_done) begin
			if (mask_d) begin
				cnt_d   = 3'd3;
				phase_d = PH_KEY;
			end else begin
				hdr_done = 1'b1;
			end
		end
		if (hdr_done) begin
			kidx_d = 2'd0;
			if (rem_d == '0) begin
				res_vld           = 1'b1;
				res.last_of_frame = 1'b1;
				frame_end         = 1'b1;
			end else begin
				phase_d = PH_DATA;
			end
		end
		if (frame_end) begin
			phase_d = (op_q == OP_CLOSE) ? PH_CLOSED : PH_HDR0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR0;
			op_q    <= '0;
			mask_q  <= 1'b0;
			rem_q   <= '0;
			cnt_q   <= '0;
			key_q   <= '0;
			kidx_q  <= '0;
		end else if (take) begin
			phase_q <= phase_d;
			op_q    <= op_d;
			mask_q  <= mask_d;
			rem_q   <= rem_d;
			cnt_q   <= cnt_d;
			key_q   <= key_d;
			kidx_q  <= kidx_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_ready && skid_valid_q) begin
			out_valid_q  <= 1'b1;
			skid_valid_q <= 1'b0;
		end else if (gen && !out_ready) begin
			skid_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= gen;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready && skid_valid_q) begin
			out_q <= skid_q;
		end else if (gen && !out_ready) begin
			skid_q <= res;
		end else if (gen) begin
			out_q <= res;
		end
	end

	assign in_stall      = skid_valid_q;
	assign out_valid     = out_valid_q;
	assign payload_byte  = out_q.payload_byte;
	assign has_byte      = out_q.has_byte;
	assign frame_opcode  = out_q.frame_opcode;
	assign frame_kind    = out_q.frame_kind;
	assign last_of_frame = out_q.last_of_frame;

	// skid entry only fills behind a held output
	`WSFD_ASSERT_SAME(a_skid_behind_out, skid_valid_q, out_valid_q)
	// nothing leaves the parser once closed
	`WSFD_ASSERT_SAME(a_closed_silent, phase_q == PH_CLOSED, !gen)
	// payload phase always has bytes left
	`WSFD_ASSERT_SAME(a_data_nonzero, phase_q == PH_DATA, rem_q != '0)
	// end of a close frame shuts the parser
	`WSFD_ASSERT_NEXT(a_close_shuts, gen && res.last_of_frame && op_q == OP_CLOSE,
		phase_q == PH_CLOSED)

endmodule

// ----- tb/websocket_frame_deframer_tb.sv -----
module websocket_frame_deframer_tb;
	import wsfd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [3:0] OP_BINARY   = 4'h2;
	localparam logic [3:0] OP_RESERVED = 4'hF;
	localparam int         RANDOM_ITEMS = 1600;
	localparam res_t       NO_RES = '0;

	typedef enum logic [2:0] {
		PH_OPCODE, PH_LENGTH, PH_EXTLEN, PH_KEY, PH_PAYLOAD, PH_SHUT
	} phase_t;

	typedef struct packed {
		logic [7:0] b;
		logic       typed;
		res_t       exp;
	} stim_row_t;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] data_byte = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] payload_byte;
	logic       has_byte;
	logic [3:0] frame_opcode;
	logic [1:0] frame_kind;
	logic       last_of_frame;

	logic quiet = 1'b0;

	// header state of the stream as the block should track it
	phase_t      ph = PH_OPCODE;
	logic [3:0]  cur_op = '0;
	logic        masked_frame = 1'b0;
	logic [63:0] bytes_left = '0;
	logic [2:0]  hdr_left = '0;
	logic [31:0] mask_key = '0;
	logic [1:0]  key_pos = '0;

	stim_row_t pending [$];
	res_t      expected [$];
	int        errors = 0;
	int        items_sent = 0;
	int        frames_sent = 0;
	int        results_checked = 0;
	int        empty_frames = 0;

	// empty text, masked empty ping, 64-bit length of one, reserved opcode with rsv bits
	stim_row_t directed_rows [22] = '{
		'{8'h81, 1'b0, NO_RES},
		'{8'h00, 1'b1, res_t'{8'h00, 1'b0, OP_TEXT, KIND_TEXT, 1'b1}},
		'{8'h89, 1'b0, NO_RES},
		'{8'h80, 1'b0, NO_RES},
		'{8'hFF, 1'b0, NO_RES},
		'{8'h00, 1'b0, NO_RES},
		'{8'hAA, 1'b0, NO_RES},
		'{8'h55, 1'b1, res_t'{8'h00, 1'b0, OP_PING, KIND_PING, 1'b1}},
		'{8'h82, 1'b0, NO_RES},
		'{8'h7F, 1'b0, NO_RES},
		'{8'h00, 1'b0, NO_RES},
		'{8'h00, 1'b0, NO_RES},
		'{8'h00, 1'b0, NO_RES},
		'{8'h00, 1'b0, NO_RES},
		'{8'h00, 1'b0, NO_RES},
		'{8'h00, 1'b0, NO_RES},
		'{8'h00, 1'b0, NO_RES},
		'{8'h01, 1'b0, NO_RES},
		'{8'hFF, 1'b1, res_t'{8'hFF, 1'b1, OP_BINARY, KIND_IGNORED, 1'b1}},
		'{8'h7F, 1'b0, NO_RES},
		'{8'h01, 1'b0, NO_RES},
		'{8'h00, 1'b1, res_t'{8'h00, 1'b1, OP_RESERVED, KIND_IGNORED, 1'b1}}
	};

	websocket_frame_deframer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.data_byte     (data_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.payload_byte  (payload_byte),
		.has_byte      (has_byte),
		.frame_opcode  (frame_opcode),
		.frame_kind    (frame_kind),
		.last_of_frame (last_of_frame)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [1:0] kind_for(input logic [3:0] op);
		if (op == OP_TEXT)
			return KIND_TEXT;
		if (op == OP_PING)
			return KIND_PING;
		if (op == OP_CLOSE)
			return KIND_CLOSE;
		return KIND_IGNORED;
	endfunction

	function automatic res_t tag_result(input logic [7:0] b, input logic has, input logic last);
		return res_t'{b, has, cur_op, kind_for(cur_op), last};
	endfunction

	task automatic end_frame();
		ph = (cur_op == OP_CLOSE) ? PH_SHUT : PH_OPCODE;
	endtask

	task automatic end_header(output bit got, output res_t r);
		got = 1'b0;
		r = NO_RES;
		key_pos = '0;
		if (bytes_left == 0) begin
			got = 1'b1;
			r = tag_result(8'h00, 1'b0, 1'b1);
			end_frame();
		end else begin
			ph = PH_PAYLOAD;
		end
	endtask

	task automatic end_length(output bit got, output res_t r);
		got = 1'b0;
		r = NO_RES;
		if (masked_frame) begin
			hdr_left = 3'd3;
			ph = PH_KEY;
		end else begin
			end_header(got, r);
		end
	endtask

	task automatic deframe_byte(input logic [7:0] b, output bit got, output res_t r);
		logic [7:0] k;
		got = 1'b0;
		r = NO_RES;
		case (ph)
			PH_OPCODE: begin
				cur_op = b[3:0];
				ph = PH_LENGTH;
			end
			PH_LENGTH: begin
				masked_frame = b[7];
				mask_key = '0;
				bytes_left = '0;
				if (b[6:0] == LEN7_EXT16) begin
					hdr_left = 3'd1;
					ph = PH_EXTLEN;
				end else if (b[6:0] == LEN7_EXT64) begin
					hdr_left = 3'd7;
					ph = PH_EXTLEN;
				end else begin
					bytes_left = 64'(b[6:0]);
					end_length(got, r);
				end
			end
			PH_EXTLEN: begin
				bytes_left = {bytes_left[55:0], b};
				if (hdr_left == 0)
					end_length(got, r);
				else
					hdr_left = hdr_left - 3'd1;
			end
			PH_KEY: begin
				mask_key = {mask_key[23:0], b};
				if (hdr_left == 0)
					end_header(got, r);
				else
					hdr_left = hdr_left - 3'd1;
			end
			PH_PAYLOAD: begin
				k = mask_key[8 * (3 - key_pos) +: 8];
				bytes_left = bytes_left - 64'd1;
				key_pos = key_pos + 2'd1;
				got = 1'b1;
				r = tag_result(b ^ k, 1'b1, bytes_left == 0);
				if (bytes_left == 0)
					end_frame();
			end
			default: begin
				// closed: everything is dropped
			end
		endcase
	endtask

	task automatic flag(input string msg);
		if (errors < 40)
			$display("%s", msg);
		errors++;
	endtask

	always @(posedge clk)
		out_stall <= !quiet && ($urandom_range(99) < 20);

	always @(posedge clk) begin
		stim_row_t row;
		res_t      pred;
		res_t      seen;
		res_t      want;
		bit        got;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				seen = {payload_byte, has_byte, frame_opcode, frame_kind, last_of_frame};
				if (expected.size() == 0) begin
					flag($sformatf("t=%0t unexpected result byte %h has %b op %h kind %0d last %b",
						$realtime, seen.payload_byte, seen.has_byte, seen.frame_opcode,
						seen.frame_kind, seen.last_of_frame));
				end else begin
					want = expected.pop_front();
					results_checked++;
					if (!seen.has_byte)
						empty_frames++;
					if (seen !== want)
						flag($sformatf({"t=%0t result %0d: got byte %h has %b op %h kind %0d ",
							"last %b, exp byte %h has %b op %h kind %0d last %b"},
							$realtime, results_checked, seen.payload_byte, seen.has_byte,
							seen.frame_opcode, seen.frame_kind, seen.last_of_frame,
							want.payload_byte, want.has_byte, want.frame_opcode,
							want.frame_kind, want.last_of_frame));
				end
			end
			if (in_valid && !in_stall && pending.size() != 0) begin
				row = pending.pop_front();
				deframe_byte(row.b, got, pred);
				if (row.typed)
					expected = {expected, row.exp};
				else if (got)
					expected = {expected, pred};
			end
		end
	end

	task automatic send_row(input stim_row_t row);
		while (!quiet && $urandom_range(99) < 20) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		pending = {pending, row};
		in_valid <= 1'b1;
		data_byte <= row.b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_row('{b, 1'b0, NO_RES});
	endtask

	task automatic send_frame(input logic [3:0] op);
		logic [7:0]  r8;
		logic [63:0] len;
		logic [31:0] key;
		logic [6:0]  len7;
		logic        masked;
		int          form;
		int          ext_bytes;
		r8 = 8'($urandom);
		masked = 1'($urandom_range(1));
		key = $urandom;
		form = $urandom_range(9);
		if (form < 7) begin
			len = 64'(($urandom_range(9) == 0) ? $urandom_range(125) : $urandom_range(12));
			ext_bytes = 0;
			len7 = len[6:0];
		end else if (form < 9) begin
			len = 64'(($urandom_range(4) == 0) ? $urandom_range(300) : $urandom_range(20));
			ext_bytes = 2;
			len7 = LEN7_EXT16;
		end else begin
			len = 64'($urandom_range(20));
			ext_bytes = 8;
			len7 = LEN7_EXT64;
		end
		send_byte({r8[7:4], op});
		send_byte({masked, len7});
		for (int i = ext_bytes - 1; i >= 0; i--)
			send_byte(len[8 * i +: 8]);
		if (masked)
			for (int i = 3; i >= 0; i--)
				send_byte(key[8 * i +: 8]);
		for (int i = 0; i < len; i++)
			send_byte(8'($urandom));
		frames_sent++;
	endtask

	initial begin
		logic [3:0] op;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_row(directed_rows[i]);
		frames_sent += 4;

		while (items_sent < RANDOM_ITEMS) begin
			// a stretch with both sides running flat out
			quiet <= (items_sent > 700 && items_sent < 1000);
			case ($urandom_range(3))
				0: op = OP_TEXT;
				1: op = OP_PING;
				default: begin
					do
						op = 4'($urandom);
					while (op == OP_CLOSE);
				end
			endcase
			send_frame(op);
		end
		quiet <= 1'b0;

		// close shuts the stream, trailing bytes must be dropped
		send_frame(OP_CLOSE);
		repeat (6)
			send_byte(8'($urandom));
		in_valid <= 1'b0;

		while (expected.size() != 0 || pending.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("ran %0d frames in %0d bytes: text, ping, close, ignored opcodes, masked",
			frames_sent, items_sent);
		$display("and bare, 7/16/64-bit lengths; %0d results checked, %0d empty-frame markers",
			results_checked, empty_frames);
		if (errors == 0)
			$display("websocket_frame_deframer_tb: PASS");
		else
			$display("websocket_frame_deframer_tb: FAIL");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("timeout with %0d results outstanding", expected.size());
		$display("websocket_frame_deframer_tb: FAIL");
		$finish;
	end

endmodule

// ----- websocket_frame_deframer.f -----
+incdir+design
design/wsfd_pkg.sv
design/websocket_frame_deframer.sv
tb/websocket_frame_deframer_tb.sv
